// ===== src/rbst_pkg.sv =====
`timescale 1ns / 1ps
package rbst_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned DiffW  = CoordW + 1;
  localparam int unsigned DistW  = 2 * CoordW;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [DiffW-1:0]  diff_t;
  typedef logic signed [DistW-1:0]  dist_t;

  // per-stage load enables of the datapath
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } pipe_en_t;

endpackage

// ===== src/rbst_slab_axis.sv =====
`timescale 1ns / 1ps
module rbst_slab_axis (
  input  logic               clk,
  input  rbst_pkg::pipe_en_t en,
  input  rbst_pkg::coord_t   box_min,
  input  rbst_pkg::coord_t   box_max,
  input  rbst_pkg::coord_t   origin,
  input  rbst_pkg::coord_t   inv_dir,
  output rbst_pkg::dist_t    t_near,
  output rbst_pkg::dist_t    t_far
);

  rbst_pkg::diff_t  d_near_r, d_near_nxt;
  rbst_pkg::diff_t  d_far_r, d_far_nxt;
  rbst_pkg::coord_t inv_r;
  rbst_pkg::dist_t  t_near_r, t_far_r;

  logic signed [rbst_pkg::DiffW+rbst_pkg::CoordW-1:0] p_near, p_far;

  // negative inverse swaps the slab order
  always_comb begin
    if (inv_dir[rbst_pkg::CoordW-1]) begin
      d_near_nxt = rbst_pkg::diff_t'(box_max) - rbst_pkg::diff_t'(origin);
      d_far_nxt  = rbst_pkg::diff_t'(box_min) - rbst_pkg::diff_t'(origin);
    end else begin
      d_near_nxt = rbst_pkg::diff_t'(box_min) - rbst_pkg::diff_t'(origin);
      d_far_nxt  = rbst_pkg::diff_t'(box_max) - rbst_pkg::diff_t'(origin);
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      d_near_r <= d_near_nxt;
      d_far_r  <= d_far_nxt;
      inv_r    <= inv_dir;
    end
  end

  // exact product always fits in 64 bits
  assign p_near = d_near_r * inv_r;
  assign p_far  = d_far_r * inv_r;

  always_ff @(posedge clk) begin
    if (en.s2) begin
      t_near_r <= p_near[rbst_pkg::DistW-1:0];
      t_far_r  <= p_far[rbst_pkg::DistW-1:0];
    end
  end

  assign t_near = t_near_r;
  assign t_far  = t_far_r;

endmodule

// ===== src/rbst_interval.sv =====
`timescale 1ns / 1ps
module rbst_interval (
  input  logic               clk,
  input  rbst_pkg::pipe_en_t en,
  input  rbst_pkg::dist_t    tx_near,
  input  rbst_pkg::dist_t    tx_far,
  input  rbst_pkg::dist_t    ty_near,
  input  rbst_pkg::dist_t    ty_far,
  input  rbst_pkg::dist_t    tz_near,
  input  rbst_pkg::dist_t    tz_far,
  output logic               hit
);

  rbst_pkg::dist_t tmin_r, tmin_nxt;
  rbst_pkg::dist_t tmax_r, tmax_nxt;
  rbst_pkg::dist_t tz_near_r, tz_far_r;
  logic            miss_r, miss_nxt;
  logic            hit_r, hit_nxt;

  always_comb begin
    miss_nxt = (tx_near > ty_far) || (ty_near > tx_far);
    tmin_nxt = (ty_near > tx_near) ? ty_near : tx_near;
    tmax_nxt = (ty_far < tx_far) ? ty_far : tx_far;
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      miss_r    <= miss_nxt;
      tmin_r    <= tmin_nxt;
      tmax_r    <= tmax_nxt;
      tz_near_r <= tz_near;
      tz_far_r  <= tz_far;
    end
  end

  // min(tmax, tz_far) > 0 split into two sign tests
  always_comb begin
    if (miss_r || (tmin_r > tz_far_r) || (tz_near_r > tmax_r)) begin
      hit_nxt = 1'b0;
    end else begin
      hit_nxt = (tmax_r > 0) && (tz_far_r > 0);
    end
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      hit_r <= hit_nxt;
    end
  end

  assign hit = hit_r;

endmodule

// ===== src/ray_box_slab_test.sv =====
`timescale 1ns / 1ps
// Ray versus axis-aligned box slab test, one hit bit per transaction.
// Input channel: in_valid / in_stall with the box corners, ray origin and
// per-axis inverse direction, all signed Q16.16. Output channel:
// out_valid / out_stall with the hit bit.
// A transaction moves when valid is high and stall is low at a clock edge.
// Registered stages, in order: corner select and subtract, 33x32 multiply,
// x/y interval intersect, z test into the output register.
// Throughput: one transaction per cycle while out_stall is low; each stage
// holds one item, so every stage loads whenever the stage after it is
// empty or moving.
// When out_stall is held, the output register keeps its result and the
// stages behind it keep filling; in_stall rises only once every stage holds
// an item. Bubbles are squeezed out, nothing is dropped or repeated.
// Reset (rst_n low, synchronous) clears all valid bits; the pipeline is
// empty afterwards and in_stall is low.
module ray_box_slab_test (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  rbst_pkg::coord_t in_box_min_x,
  input  rbst_pkg::coord_t in_box_min_y,
  input  rbst_pkg::coord_t in_box_min_z,
  input  rbst_pkg::coord_t in_box_max_x,
  input  rbst_pkg::coord_t in_box_max_y,
  input  rbst_pkg::coord_t in_box_max_z,
  input  rbst_pkg::coord_t in_origin_x,
  input  rbst_pkg::coord_t in_origin_y,
  input  rbst_pkg::coord_t in_origin_z,
  input  rbst_pkg::coord_t in_inv_dir_x,
  input  rbst_pkg::coord_t in_inv_dir_y,
  input  rbst_pkg::coord_t in_inv_dir_z,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_hit
);

  logic v1_r, v2_r, v3_r, v4_r;
  rbst_pkg::pipe_en_t en;
  rbst_pkg::dist_t tx_near, tx_far, ty_near, ty_far, tz_near, tz_far;

  always_comb begin
    en.s4 = !v4_r || !out_stall;
    en.s3 = !v3_r || en.s4;
    en.s2 = !v2_r || en.s3;
    en.s1 = !v1_r || en.s2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en.s1) v1_r <= in_valid;
      if (en.s2) v2_r <= v1_r;
      if (en.s3) v3_r <= v2_r;
      if (en.s4) v4_r <= v3_r;
    end
  end

  rbst_slab_axis u_axis_x (
    .clk     (clk),
    .en      (en),
    .box_min (in_box_min_x),
    .box_max (in_box_max_x),
    .origin  (in_origin_x),
    .inv_dir (in_inv_dir_x),
    .t_near  (tx_near),
    .t_far   (tx_far)
  );

  rbst_slab_axis u_axis_y (
    .clk     (clk),
    .en      (en),
    .box_min (in_box_min_y),
    .box_max (in_box_max_y),
    .origin  (in_origin_y),
    .inv_dir (in_inv_dir_y),
    .t_near  (ty_near),
    .t_far   (ty_far)
  );

  rbst_slab_axis u_axis_z (
    .clk     (clk),
    .en      (en),
    .box_min (in_box_min_z),
    .box_max (in_box_max_z),
    .origin  (in_origin_z),
    .inv_dir (in_inv_dir_z),
    .t_near  (tz_near),
    .t_far   (tz_far)
  );

  rbst_interval u_interval (
    .clk     (clk),
    .en      (en),
    .tx_near (tx_near),
    .tx_far  (tx_far),
    .ty_near (ty_near),
    .ty_far  (ty_far),
    .tz_near (tz_near),
    .tz_far  (tz_far),
    .hit     (out_hit)
  );

  assign in_stall  = !en.s1;
  assign out_valid = v4_r;

endmodule
